@@ src/b2d_pkg.sv @@
// ----------------------------------------------------------------------------
// b2d_pkg
// shared constants and types for the binary to decimal digit unit
// ----------------------------------------------------------------------------
package b2d_pkg;

   localparam int IN_W        = 32;
   localparam int VALUE_BITS  = 32;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_W     = 4;
   localparam int POS_W       = 4;
   localparam int BCD_W       = DIGIT_W * MAX_DIGITS;
   localparam int STEP_W      = $clog2(VALUE_BITS + 1);
   localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W       = $clog2(MAX_DIGITS);
   localparam int FRONT_DEPTH = 2;
   localparam int FPTR_W      = $clog2(FRONT_DEPTH);
   localparam int FCNT_W      = $clog2(FRONT_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  is_zero;
   } b2d_item_type;

   typedef struct packed {
      logic         valid;
      b2d_item_type item;
   } b2d_queue_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } b2d_state_type;

endpackage

@@ src/b2d_front.sv @@
// ----------------------------------------------------------------------------
// b2d_front
// input queue: takes values, flags zero, holds them for the converter
// ----------------------------------------------------------------------------
module b2d_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [b2d_pkg::IN_W-1:0]   req_value,
   output b2d_pkg::b2d_queue_type     item_out,
   input  logic                       item_ready
);
   import b2d_pkg::*;

   logic [VALUE_BITS-1:0] value_ff [FRONT_DEPTH];
   logic [VALUE_BITS-1:0] value_in;
   logic                  zero_ff  [FRONT_DEPTH];
   logic                  zero_in;
   logic [FPTR_W-1:0]     wr_ff, wr_in;
   logic [FPTR_W-1:0]     rd_ff, rd_in;
   logic [FCNT_W-1:0]     count_ff, count_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign req_full = (count_ff == FCNT_W'(FRONT_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = item_out.valid && item_ready;

   // classify
   assign value_in = req_value[VALUE_BITS-1:0];
   assign zero_in  = (value_in == '0);

   assign item_out.valid        = (count_ff != '0);
   assign item_out.item.value   = value_ff[rd_ff];
   assign item_out.item.is_zero = zero_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_in = (wr_ff == FPTR_W'(FRONT_DEPTH - 1)) ? '0 : wr_ff + FPTR_W'(1);
      end
      if (pop_ok) begin
         rd_in = (rd_ff == FPTR_W'(FRONT_DEPTH - 1)) ? '0 : rd_ff + FPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + FCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - FCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         value_ff[wr_ff] <= value_in;
         zero_ff[wr_ff]  <= zero_in;
      end
   end

endmodule

@@ src/b2d_back.sv @@
// ----------------------------------------------------------------------------
// b2d_back
// double-dabble converter and digit emitter with an output register
// ----------------------------------------------------------------------------
module b2d_back (
   input  logic                            clock,
   input  logic                            reset,
   input  b2d_pkg::b2d_queue_type          item_in,
   output logic                            item_ready,
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output logic [b2d_pkg::DIGIT_W-1:0]     rsp_digit,
   output logic [b2d_pkg::POS_W-1:0]       rsp_position,
   output logic                            rsp_last
);
   import b2d_pkg::*;

   b2d_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] binary_ff, binary_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DIGIT_W-1:0]    digit_ff, digit_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  last_ff, last_in;

   logic                  take;
   logic                  emit_fire;
   logic                  step_done;
   logic                  emit_last;
   logic [IDX_W-1:0]      src_idx;
   logic [CNT_W-1:0]      size_total;

   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
      logic [BCD_W-1:0] adj;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         adj[k*DIGIT_W +: DIGIT_W] = (bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
            bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) : bcd[k*DIGIT_W +: DIGIT_W];
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   // highest nonzero digit, at least one digit
   always_comb begin
      size_total = CNT_W'(1);
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (bcd_ff[k*DIGIT_W +: DIGIT_W] != '0) begin
            size_total = CNT_W'(k + 1);
         end
      end
   end

   assign step_done = (step_ff == STEP_W'(VALUE_BITS - 1));
   assign emit_last = (idx_ff == total_ff - CNT_W'(1));
   assign src_idx   = IDX_W'(total_ff - CNT_W'(1) - idx_ff);

   // outputs of the sequencer
   always_comb begin
      item_ready = (state_ff == ST_IDLE);
      take       = (state_ff == ST_IDLE) && item_in.valid;
      emit_fire  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_in.valid) begin
               state_in = item_in.item.is_zero ? ST_EMIT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (step_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      binary_in    = binary_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      digit_in     = digit_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      if (take) begin
         binary_in = item_in.item.value;
         bcd_in    = '0;
         step_in   = '0;
         total_in  = CNT_W'(1);
         idx_in    = '0;
      end
      if (state_ff == ST_CONVERT) begin
         bcd_in    = dabble(bcd_ff, binary_ff[VALUE_BITS-1]);
         binary_in = binary_ff << 1;
         step_in   = step_done ? '0 : step_ff + STEP_W'(1);
      end
      if (state_ff == ST_SIZE) begin
         total_in = size_total;
         idx_in   = '0;
      end
      if (emit_fire) begin
         digit_in     = bcd_ff[src_idx*DIGIT_W +: DIGIT_W];
         pos_in       = POS_W'(idx_ff);
         last_in      = emit_last;
         idx_in       = idx_ff + CNT_W'(1);
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         binary_ff    <= '0;
         bcd_ff       <= '0;
         step_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         binary_ff    <= binary_in;
         bcd_ff       <= bcd_in;
         step_ff      <= step_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_digit    = digit_ff;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;

   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result loaded outside emit state");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> total_ff != '0 && total_ff <= CNT_W'(MAX_DIGITS)
                              && idx_ff < total_ff)
      else $error("emit index out of range");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      emit_fire && emit_last |=> state_ff == ST_IDLE && out_valid_ff && rsp_last)
      else $error("last digit did not close the transaction");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIZE |-> step_ff == '0)
      else $error("step counter not cleared after conversion");

endmodule

@@ src/binary_to_decimal_digits_unit.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_unit
// splits an unsigned binary value into its decimal digits, most significant
// first, one result transaction per digit
// ----------------------------------------------------------------------------
// A pushed value enters a two-entry input queue, then the converter runs one
// double-dabble step per cycle through its shared add-3 and shift unit, one
// step per value bit, finds the top significant digit in the size state, then
// moves one digit per cycle into the output register while that register is
// empty or being popped; zero skips the conversion. Leading zeros are dropped
// and zero gives the single digit 0. The next value is taken while the last
// digit of the previous one waits.
module binary_to_decimal_digits_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [b2d_pkg::IN_W-1:0]      req_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [b2d_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic [b2d_pkg::POS_W-1:0]     rsp_position,
   output logic                          rsp_last
);
   import b2d_pkg::*;

   b2d_queue_type queue_item;
   logic          queue_ready;

   b2d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_value  (req_value),
      .item_out   (queue_item),
      .item_ready (queue_ready)
   );

   b2d_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_in      (queue_item),
      .item_ready   (queue_ready),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_digit    (rsp_digit),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for binary_to_decimal_digits_unit
// ----------------------------------------------------------------------------
// Pushes unsigned values through the input queue and checks every digit
// transaction against typed digits or the bench's double-dabble predictor. A short
// table of directed values comes first, then random values in three idle
// patterns, with one long output hold and one full drain on the way.
// ----------------------------------------------------------------------------
module testbench;
   import b2d_pkg::*;

   localparam int DIRECTED_N   = 20;
   localparam int PHASE_VALUES = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [POS_W-1:0]   position;
      logic               last;
   } digit_txn_type;

   typedef struct packed {
      logic [IN_W-1:0]  value;
      logic             typed;
      logic [BCD_W-1:0] digits;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [IN_W-1:0]     req_value = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [DIGIT_W-1:0]  rsp_digit;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_last;

   digit_txn_type awaited_digits[$];
   int         error_count = 0;
   int         values_sent = 0;
   int         digits_checked = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_left = 0;
   bit         hold_off_request = 1'b0;

   // decimal digits packed in hex: the row's typed result reads as the number
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{32'd0,          1'b1, 40'h0},
      '{32'd1,          1'b1, 40'h1},
      '{32'd9,          1'b1, 40'h9},
      '{32'd10,         1'b1, 40'h10},
      '{32'd4294967295, 1'b1, 40'h4294967295},
      '{32'd1000000000, 1'b1, 40'h1000000000},
      '{32'd99,         1'b0, 40'h0},
      '{32'd100,        1'b0, 40'h0},
      '{32'd5,          1'b0, 40'h0},
      '{32'd4,          1'b0, 40'h0},
      '{32'd999999999,  1'b0, 40'h0},
      '{32'd2147483648, 1'b0, 40'h0},
      '{32'd4000000000, 1'b0, 40'h0},
      '{32'd123456789,  1'b0, 40'h0},
      '{32'h55555555,   1'b0, 40'h0},
      '{32'hAAAAAAAA,   1'b0, 40'h0},
      '{32'hFFFFFFFE,   1'b0, 40'h0},
      '{32'd1000000001, 1'b0, 40'h0},
      '{32'd65535,      1'b0, 40'h0},
      '{32'd3999999999, 1'b0, 40'h0}
   };

   binary_to_decimal_digits_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_value    (req_value),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_digit    (rsp_digit),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   // shift-and-add-3, one step per input bit, msb first
   function automatic logic [BCD_W-1:0] to_packed_decimal(input logic [IN_W-1:0] value);
      logic [BCD_W-1:0] bcd;
      bcd = '0;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
         for (int k = 0; k < MAX_DIGITS; k++) begin
            if (bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               bcd[k*DIGIT_W +: DIGIT_W] = bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         bcd = {bcd[BCD_W-2:0], value[b]};
      end
      return bcd;
   endfunction

   task automatic report_mismatch(input string what, input int actual, input int wanted);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d",
               cycle_count, what, actual, wanted);
      error_count++;
   endtask

   task automatic send_value(input logic [IN_W-1:0] value, input logic typed,
                             input logic [BCD_W-1:0] typed_digits);
      logic [BCD_W-1:0] digits;
      int               count;
      digit_txn_type    txn;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
      digits = typed ? typed_digits : to_packed_decimal(value);
      count = 1;
      for (int k = 1; k < MAX_DIGITS; k++) begin
         if (digits[k*DIGIT_W +: DIGIT_W] != '0) count = k + 1;
      end
      for (int i = 0; i < count; i++) begin
         txn.digit    = digits[(count-1-i)*DIGIT_W +: DIGIT_W];
         txn.position = POS_W'(i);
         txn.last     = (i == count - 1);
         awaited_digits.push_back(txn);
      end
      values_sent++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side: check each accepted transaction, then pick the next pop
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_digits.size() == 0) begin
               report_mismatch("unexpected digit", rsp_digit, -1);
            end else begin
               if (rsp_digit !== awaited_digits[0].digit)
                  report_mismatch("digit", rsp_digit, awaited_digits[0].digit);
               if (rsp_position !== awaited_digits[0].position)
                  report_mismatch("position", rsp_position, awaited_digits[0].position);
               if (rsp_last !== awaited_digits[0].last)
                  report_mismatch("last", rsp_last, awaited_digits[0].last);
               void'(awaited_digits.pop_front());
               digits_checked++;
            end
         end
         if (hold_off_request) begin
            hold_left = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int                kind;
      int                width;
      longint unsigned   pow;
      logic [IN_W-1:0]   value;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 51;
      for (int r = 0; r < DIRECTED_N; r++) begin
         send_value(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].digits);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 51;
            end
            1: begin
               // let the unit drain completely before changing pattern
               req_push <= 1'b0;
               do @(posedge clock); while (awaited_digits.size() != 0);
               send_idle_pct = 51;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_off_request = 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_VALUES; n++) begin
            kind = $urandom_range(9);
            case (kind)
               6, 7: value = $urandom;
               8: begin
                  pow = 1;
                  repeat ($urandom_range(9)) pow = pow * 10;
                  value = IN_W'(pow + $urandom_range(2) - 1);
               end
               9: value = $urandom_range(1) ? '1 : '0;
               default: begin
                  width = $urandom_range(32, 1);
                  value = $urandom >> (32 - width);
               end
            endcase
            send_value(value, 1'b0, '0);
         end
      end

      req_push <= 1'b0;
      do @(posedge clock); while (awaited_digits.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d values pushed, %0d digit transactions checked, %0d mismatches",
               values_sent, digits_checked, error_count);
      $display("summary: directed table, three idle patterns, a %0d-cycle output hold",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
